FILE: src/one_wire_thermometer_slave_assert.svh
// ----------------------------------------------------------------------------
// one-wire thermometer slave: assertion macros
// shared property forms used by the block's assertions
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_THERMOMETER_SLAVE_ASSERT_SVH
`define ONE_WIRE_THERMOMETER_SLAVE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define OWTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("owts: same-cycle check failed");

// next-cycle implication, checked outside reset
`define OWTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("owts: next-cycle check failed");

`endif

FILE: src/owts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owts_pkg
// shared types and constants of the one-wire thermometer slave
// ----------------------------------------------------------------------------
package owts_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 48;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_TEMPERATURE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALARM_HIGH  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ALARM_LOW   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CONFIG_BYTE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SERIAL      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_PARASITE    = 3'd5;

	// configuration reset values
	localparam logic [11:0] TEMPERATURE_RST = 12'd352;
	localparam logic [7:0]  ALARM_HIGH_RST  = 8'd75;
	localparam logic [7:0]  ALARM_LOW_RST   = 8'd70;
	localparam logic [7:0]  CONFIG_BYTE_RST = 8'd127;

	// fixed image bytes and the crc polynomial
	localparam logic [7:0] FAMILY_CODE  = 8'h28;
	localparam logic [7:0] PAD_RESERVED = 8'hFF;
	localparam logic [7:0] PAD_BYTE6    = 8'h0C;
	localparam logic [7:0] PAD_BYTE7    = 8'h10;
	localparam logic [7:0] CRC_POLY     = 8'h8C;

	// command codes
	localparam logic [7:0] CMD_READ_ROM    = 8'h33;
	localparam logic [7:0] CMD_CONVERT     = 8'h44;
	localparam logic [7:0] CMD_MATCH_ROM   = 8'h55;
	localparam logic [7:0] CMD_READ_POWER  = 8'hB4;
	localparam logic [7:0] CMD_READ_PAD    = 8'hBE;
	localparam logic [7:0] CMD_SKIP_ROM    = 8'hCC;
	localparam logic [7:0] CMD_SEARCH_ROM  = 8'hF0;

	// pulse timing in microseconds
	localparam int RESET_MIN_US = 475;
	localparam int ZERO_MIN_US  = 60;
	localparam logic [4:0] PRESENCE_DELAY = 5'd30;
	localparam logic [9:0] PRESENCE_WIDTH = 10'd80;
	localparam logic [4:0] SLOT_DELAY     = 5'd1;
	localparam logic [9:0] ZERO_WIDTH     = 10'd50;
	localparam logic [9:0] BUSY_WIDTH     = 10'd749;

	// ROM and scratchpad images, byte 0 in the low bits
	typedef struct packed {
		logic        busy;
		logic        parasite;
		logic [71:0] pad;
		logic [63:0] rom;
	} image_t;

endpackage

FILE: src/owts_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owts_cfg
// configuration registers, ROM and scratchpad images with their CRC bytes
// ----------------------------------------------------------------------------
module owts_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [owts_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [owts_pkg::CFG_DATA_W-1:0]      cfg_data,
	output owts_pkg::image_t                     image
);

	logic [11:0] temp_q;
	logic [7:0]  alarm_hi_q;
	logic [7:0]  alarm_lo_q;
	logic [7:0]  cfg_byte_q;
	logic [47:0] serial_q;
	logic        parasite_q;

	logic [7:0]  rom_crc_q;
	logic [7:0]  pad_crc_q;
	logic [2:0]  crc_idx_q;
	logic        crc_busy_q;

	logic [63:0] rom_pre;
	logic [63:0] pad_pre;
	logic [7:0]  rom_in;
	logic [7:0]  pad_in;

	// one byte through the reflected crc, bit by bit
	function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		logic [7:0] d;
		c = crc_in;
		d = data;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ d[0])
				c = (c >> 1) ^ owts_pkg::CRC_POLY;
			else
				c = c >> 1;
			d = d >> 1;
		end
		return c;
	endfunction

	// top byte of rom_pre is padding and never fed to the crc
	assign rom_pre = {8'h00, serial_q, owts_pkg::FAMILY_CODE};
	assign pad_pre = {owts_pkg::PAD_BYTE7, owts_pkg::PAD_BYTE6, owts_pkg::PAD_RESERVED,
		cfg_byte_q, alarm_lo_q, alarm_hi_q, {4{temp_q[11]}}, temp_q};

	assign rom_in = rom_pre[{crc_idx_q, 3'b000} +: 8];
	assign pad_in = pad_pre[{crc_idx_q, 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q     <= owts_pkg::TEMPERATURE_RST;
			alarm_hi_q <= owts_pkg::ALARM_HIGH_RST;
			alarm_lo_q <= owts_pkg::ALARM_LOW_RST;
			cfg_byte_q <= owts_pkg::CONFIG_BYTE_RST;
			serial_q   <= '0;
			parasite_q <= 1'b0;
			rom_crc_q  <= '0;
			pad_crc_q  <= '0;
			crc_idx_q  <= '0;
			crc_busy_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				owts_pkg::REG_TEMPERATURE: temp_q     <= cfg_data[11:0];
				owts_pkg::REG_ALARM_HIGH:  alarm_hi_q <= cfg_data[7:0];
				owts_pkg::REG_ALARM_LOW:   alarm_lo_q <= cfg_data[7:0];
				owts_pkg::REG_CONFIG_BYTE: cfg_byte_q <= cfg_data[7:0];
				owts_pkg::REG_SERIAL:      serial_q   <= cfg_data[47:0];
				owts_pkg::REG_PARASITE:    parasite_q <= cfg_data[0];
				default: ;
			endcase
			// restart the crc pass over the new images
			rom_crc_q  <= '0;
			pad_crc_q  <= '0;
			crc_idx_q  <= '0;
			crc_busy_q <= 1'b1;
		end else if (crc_busy_q) begin
			if (crc_idx_q != 3'd7)
				rom_crc_q <= crc_byte(rom_crc_q, rom_in);
			pad_crc_q <= crc_byte(pad_crc_q, pad_in);
			crc_idx_q <= crc_idx_q + 3'd1;
			if (crc_idx_q == 3'd7)
				crc_busy_q <= 1'b0;
		end
	end

	assign image.busy     = crc_busy_q;
	assign image.parasite = parasite_q;
	assign image.rom      = {rom_crc_q, rom_pre[55:0]};
	assign image.pad      = {pad_crc_q, pad_pre};

endmodule

FILE: src/owts_link.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owts_link
// slot decoder and protocol state: one low pulse per beat, one result per beat
// ----------------------------------------------------------------------------
`include "one_wire_thermometer_slave_assert.svh"

module owts_link #(
	parameter int TIME_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  owts_pkg::image_t      image,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [TIME_BITS-1:0]  low_time_us,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  pulse_request,
	output logic [4:0]            pulse_delay_us,
	output logic [9:0]            pulse_width_us,
	output logic [2:0]            protocol_state,
	output logic                  slot_error,
	output logic                  byte_valid,
	output logic [7:0]            received_byte
);

	typedef enum logic [2:0] {
		LS_IDLE    = 3'd0,
		LS_COMMAND = 3'd1,
		LS_DATA    = 3'd2,
		LS_MATCH   = 3'd3,
		LS_SEARCH  = 3'd4
	} link_state_t;

	localparam logic [TIME_BITS-1:0] RESET_MIN = TIME_BITS'(owts_pkg::RESET_MIN_US);
	localparam logic [TIME_BITS-1:0] ZERO_MIN  = TIME_BITS'(owts_pkg::ZERO_MIN_US);

	// input stage
	logic                 valid_s1;
	logic [TIME_BITS-1:0] time_s1;

	// protocol state
	link_state_t link_q;
	logic [5:0]  bp_q;
	logic [5:0]  fb_q;
	logic [7:0]  rx_q;
	logic [7:0]  txb_q;
	logic        tx_q;
	logic [3:0]  bl_q;
	logic        ssp_q;
	logic [6:0]  sp_q;
	logic        se_q;

	// result register
	logic        out_valid_q;
	logic        pulse_request_q;
	logic [4:0]  pulse_delay_q;
	logic [9:0]  pulse_width_q;
	logic [2:0]  protocol_state_q;
	logic        slot_error_q;
	logic        byte_valid_q;
	logic [7:0]  received_byte_q;

	// next values
	link_state_t n_link;
	logic [5:0]  n_bp;
	logic [5:0]  n_fb;
	logic [7:0]  n_rx;
	logic [7:0]  n_txb;
	logic        n_tx;
	logic [3:0]  n_bl;
	logic        n_ssp;
	logic [6:0]  n_sp;
	logic        n_se;
	logic        req;
	logic [4:0]  dly;
	logic [9:0]  wid;
	logic        err;
	logic        bv;
	logic [7:0]  rb;
	logic        long_pulse;
	logic        bit_in;
	logic [7:0]  rx_new;
	logic [3:0]  total;

	logic        advance;

	// byte idx of the ROM or scratchpad image
	function automatic logic [7:0] buf_byte(input logic pad_sel, input logic [3:0] idx,
		input logic [63:0] rom, input logic [71:0] pad);
		logic [7:0] b;
		b = 8'h00;
		if (pad_sel) begin
			if (idx <= 4'd8)
				b = pad[{idx, 3'b000} +: 8];
		end else begin
			b = rom[{idx[2:0], 3'b000} +: 8];
		end
		return b;
	endfunction

	always_comb begin
		n_link     = link_q;
		n_bp       = bp_q;
		n_fb       = fb_q;
		n_rx       = rx_q;
		n_txb      = txb_q;
		n_tx       = tx_q;
		n_bl       = bl_q;
		n_ssp      = ssp_q;
		n_sp       = sp_q;
		n_se       = se_q;
		req        = 1'b0;
		dly        = '0;
		wid        = '0;
		err        = 1'b0;
		bv         = 1'b0;
		rb         = '0;
		long_pulse = time_s1 > ZERO_MIN;
		bit_in     = ~long_pulse;
		rx_new     = rx_q;
		total      = ssp_q ? 4'd9 : 4'd8;

		if (time_s1 > RESET_MIN) begin
			// bus reset, answer with presence
			n_rx   = '0;
			n_bp   = '0;
			n_fb   = 6'd7;
			n_link = LS_COMMAND;
			n_tx   = 1'b0;
			n_bl   = '0;
			req    = 1'b1;
			dly    = owts_pkg::PRESENCE_DELAY;
			wid    = owts_pkg::PRESENCE_WIDTH;
		end else if (link_q != LS_IDLE) begin
			if (tx_q) begin
				if (long_pulse) begin
					err = 1'b1;
				end else begin
					// read slot: a zero bit pulls the line
					if (!txb_q[bp_q[2:0]]) begin
						req = 1'b1;
						dly = owts_pkg::SLOT_DELAY;
						wid = owts_pkg::ZERO_WIDTH;
					end
					if (bp_q == fb_q) begin
						n_bp = '0;
						n_tx = 1'b0;
						if (link_q == LS_SEARCH) begin
							n_fb = '0;
						end else if (bl_q != 4'd0) begin
							n_bl = bl_q - 4'd1;
							if (n_bl != 4'd0) begin
								n_txb = buf_byte(ssp_q, total - n_bl, image.rom, image.pad);
								n_fb  = 6'd7;
								n_tx  = 1'b1;
							end
						end
					end else begin
						n_bp = bp_q + 6'd1;
					end
				end
			end else begin
				if (link_q == LS_MATCH) begin
					if (bit_in != image.rom[bp_q])
						n_link = LS_IDLE;
				end else if (bit_in) begin
					rx_new[bp_q[2:0]] = 1'b1;
				end
				if (bp_q == fb_q) begin
					n_bp = '0;
					n_fb = 6'd7;
					n_rx = '0;
					case (n_link)
						LS_COMMAND: begin
							bv     = 1'b1;
							rb     = rx_new;
							n_link = LS_DATA;
							case (rx_new)
								owts_pkg::CMD_READ_ROM: begin
									n_ssp = 1'b0;
									n_bl  = 4'd8;
									n_txb = buf_byte(1'b0, 4'd0, image.rom, image.pad);
									n_tx  = 1'b1;
								end
								owts_pkg::CMD_CONVERT: begin
									n_link = LS_IDLE;
									if (!image.parasite) begin
										req = 1'b1;
										dly = owts_pkg::SLOT_DELAY;
										wid = owts_pkg::BUSY_WIDTH;
									end
								end
								owts_pkg::CMD_MATCH_ROM: begin
									n_fb   = 6'd63;
									n_link = LS_MATCH;
								end
								owts_pkg::CMD_READ_POWER: ;
								owts_pkg::CMD_READ_PAD: begin
									n_ssp = 1'b1;
									n_bl  = 4'd9;
									n_txb = buf_byte(1'b1, 4'd0, image.rom, image.pad);
									n_tx  = 1'b1;
								end
								owts_pkg::CMD_SKIP_ROM: n_link = LS_COMMAND;
								owts_pkg::CMD_SEARCH_ROM: begin
									n_link = LS_SEARCH;
									n_sp   = '0;
									n_se   = image.rom[0];
									n_txb  = image.rom[0] ? 8'd1 : 8'd2;
									n_fb   = 6'd1;
									n_tx   = 1'b1;
								end
								default: n_link = LS_IDLE;
							endcase
						end
						LS_DATA: begin
							bv = 1'b1;
							rb = rx_new;
						end
						LS_MATCH: n_link = LS_COMMAND;
						LS_SEARCH: begin
							if (rx_new[0] != se_q) begin
								n_link = LS_IDLE;
							end else begin
								n_sp = sp_q + 7'd1;
								if (n_sp[6]) begin
									n_link = LS_IDLE;
								end else begin
									// next ROM bit and its complement
									n_se  = image.rom[n_sp[5:0]];
									n_txb = image.rom[n_sp[5:0]] ? 8'd1 : 8'd2;
									n_fb  = 6'd1;
									n_tx  = 1'b1;
								end
							end
						end
						default: ;
					endcase
				end else begin
					n_bp = bp_q + 6'd1;
					n_rx = rx_new;
				end
			end
		end
	end

	assign advance  = ~(out_valid_q & out_stall);
	assign in_stall = image.busy | (valid_s1 & ~advance);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			time_s1          <= '0;
			link_q           <= LS_IDLE;
			bp_q             <= '0;
			fb_q             <= 6'd7;
			rx_q             <= '0;
			txb_q            <= '0;
			tx_q             <= 1'b0;
			bl_q             <= '0;
			ssp_q            <= 1'b0;
			sp_q             <= '0;
			se_q             <= 1'b0;
			out_valid_q      <= 1'b0;
			pulse_request_q  <= 1'b0;
			pulse_delay_q    <= '0;
			pulse_width_q    <= '0;
			protocol_state_q <= '0;
			slot_error_q     <= 1'b0;
			byte_valid_q     <= 1'b0;
			received_byte_q  <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
				time_s1  <= low_time_us;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					link_q           <= n_link;
					bp_q             <= n_bp;
					fb_q             <= n_fb;
					rx_q             <= n_rx;
					txb_q            <= n_txb;
					tx_q             <= n_tx;
					bl_q             <= n_bl;
					ssp_q            <= n_ssp;
					sp_q             <= n_sp;
					se_q             <= n_se;
					pulse_request_q  <= req;
					pulse_delay_q    <= dly;
					pulse_width_q    <= wid;
					protocol_state_q <= n_link;
					slot_error_q     <= err;
					byte_valid_q     <= bv;
					received_byte_q  <= rb;
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign pulse_request  = pulse_request_q;
	assign pulse_delay_us = pulse_delay_q;
	assign pulse_width_us = pulse_width_q;
	assign protocol_state = protocol_state_q;
	assign slot_error     = slot_error_q;
	assign byte_valid     = byte_valid_q;
	assign received_byte  = received_byte_q;

	`OWTS_ASSERT_NOW(a_req_width, clk, arst_n, out_valid_q, pulse_request_q == (pulse_width_q != 10'd0))
	`OWTS_ASSERT_NOW(a_byte_zero, clk, arst_n, out_valid_q && !byte_valid_q, received_byte_q == 8'd0)
	`OWTS_ASSERT_NOW(a_err_quiet, clk, arst_n, out_valid_q && slot_error_q, !pulse_request_q && !byte_valid_q)
	`OWTS_ASSERT_NOW(a_tx_size, clk, arst_n, tx_q, fb_q == 6'd7 || fb_q == 6'd1)

endmodule

FILE: src/one_wire_thermometer_slave.sv
`timescale 1ns / 1ps
// a pulse beat is held in the input stage, its result in the result register
// throughput: one pulse beat per cycle unless stalled; one state update per slot
// reset: asynchronous, link goes idle and configuration takes its default values
// after reset and after every configuration write the input stalls
// while the crc unit walks the ROM and scratchpad images one byte per cycle
// ----------------------------------------------------------------------------
// one_wire_thermometer_slave
// slave side of a one-wire temperature sensor with ROM functions
// ----------------------------------------------------------------------------
module one_wire_thermometer_slave #(
	parameter int TIME_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [owts_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [owts_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [TIME_BITS-1:0]                 low_time_us,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 pulse_request,
	output logic [4:0]                           pulse_delay_us,
	output logic [9:0]                           pulse_width_us,
	output logic [2:0]                           protocol_state,
	output logic                                 slot_error,
	output logic                                 byte_valid,
	output logic [7:0]                           received_byte
);

	owts_pkg::image_t image;

	owts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.image     (image)
	);

	owts_link #(
		.TIME_BITS (TIME_BITS)
	) u_link (
		.clk            (clk),
		.arst_n         (arst_n),
		.image          (image),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.low_time_us    (low_time_us),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pulse_request  (pulse_request),
		.pulse_delay_us (pulse_delay_us),
		.pulse_width_us (pulse_width_us),
		.protocol_state (protocol_state),
		.slot_error     (slot_error),
		.byte_valid     (byte_valid),
		.received_byte  (received_byte)
	);

endmodule

FILE: tb/owts_slot_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owts_slot_checker
// watches the slot and result channels of the one-wire slave and the
// register port. keeps its own model of the slave, predicts the answer to
// every pulse beat and compares it field by field with the result beats
// ----------------------------------------------------------------------------
module owts_slot_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [owts_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [owts_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [11:0]                      low_time_us,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             pulse_request,
	input  logic [4:0]                       pulse_delay_us,
	input  logic [9:0]                       pulse_width_us,
	input  logic [2:0]                       protocol_state,
	input  logic                             slot_error,
	input  logic                             byte_valid,
	input  logic [7:0]                       received_byte,
	output int                               fail_count,
	output int                               awaiting,
	output logic [63:0]                      rom_image
);

	typedef enum logic [2:0] {
		LINK_IDLE    = 3'd0,
		LINK_COMMAND = 3'd1,
		LINK_DATA    = 3'd2,
		LINK_MATCH   = 3'd3,
		LINK_SEARCH  = 3'd4
	} link_t;

	typedef struct packed {
		logic       req;
		logic [4:0] delay;
		logic [9:0] width;
		logic [2:0] state;
		logic       err;
		logic       got_byte;
		logic [7:0] data;
	} slot_answer_t;

	// register copies
	logic [11:0] temperature;
	logic [7:0]  alarm_hi;
	logic [7:0]  alarm_lo;
	logic [7:0]  resolution;
	logic [47:0] serial;
	logic        parasite;
	logic [63:0] rom_now;

	// link model
	link_t       link;
	logic [5:0]  bit_pos;
	logic [5:0]  last_pos;
	logic [7:0]  rx_shift;
	logic [7:0]  tx_byte;
	logic        tx_busy;
	logic [3:0]  bytes_left;
	logic        from_pad;
	logic [6:0]  search_pos;
	logic        search_bit;

	slot_answer_t answer;
	slot_answer_t oldest;
	slot_answer_t expected_answers[$];

	function automatic logic [7:0] dallas_crc(input logic [71:0] bytes, input int count);
		logic [7:0] crc;
		logic [7:0] b;
		logic       mix;
		crc = 8'h00;
		for (int i = 0; i < count; i++) begin
			b = bytes[8*i +: 8];
			for (int k = 0; k < 8; k++) begin
				mix = crc[0] ^ b[0];
				crc = crc >> 1;
				if (mix)
					crc = crc ^ owts_pkg::CRC_POLY;
				b = b >> 1;
			end
		end
		return crc;
	endfunction

	function automatic logic [63:0] rom_of(input logic [47:0] sn);
		logic [63:0] r;
		r[7:0]   = owts_pkg::FAMILY_CODE;
		r[55:8]  = sn;
		r[63:56] = dallas_crc({8'h00, r}, 7);
		return r;
	endfunction

	function automatic logic [71:0] pad_of();
		logic [71:0] p;
		p[15:0]  = {{4{temperature[11]}}, temperature};
		p[23:16] = alarm_hi;
		p[31:24] = alarm_lo;
		p[39:32] = resolution;
		p[47:40] = owts_pkg::PAD_RESERVED;
		p[55:48] = owts_pkg::PAD_BYTE6;
		p[63:56] = owts_pkg::PAD_BYTE7;
		p[71:64] = dallas_crc(p, 8);
		return p;
	endfunction

	function automatic void restore_defaults();
		temperature = owts_pkg::TEMPERATURE_RST;
		alarm_hi    = owts_pkg::ALARM_HIGH_RST;
		alarm_lo    = owts_pkg::ALARM_LOW_RST;
		resolution  = owts_pkg::CONFIG_BYTE_RST;
		serial      = '0;
		parasite    = 1'b0;
		rom_now     = rom_of('0);
		link        = LINK_IDLE;
		bit_pos     = '0;
		last_pos    = 6'd7;
		rx_shift    = '0;
		tx_byte     = '0;
		tx_busy     = 1'b0;
		bytes_left  = '0;
		from_pad    = 1'b0;
		search_pos  = '0;
		search_bit  = 1'b0;
	endfunction

	function automatic void apply_register(input logic [owts_pkg::CFG_INDEX_W-1:0] idx,
			input logic [owts_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			owts_pkg::REG_TEMPERATURE: temperature = val[11:0];
			owts_pkg::REG_ALARM_HIGH:  alarm_hi = val[7:0];
			owts_pkg::REG_ALARM_LOW:   alarm_lo = val[7:0];
			owts_pkg::REG_CONFIG_BYTE: resolution = val[7:0];
			owts_pkg::REG_SERIAL: begin
				serial  = val[47:0];
				rom_now = rom_of(val[47:0]);
			end
			owts_pkg::REG_PARASITE:    parasite = val[0];
			default: ;
		endcase
	endfunction

	function automatic void pull_low(input logic [4:0] d, input logic [9:0] w);
		answer.req   = 1'b1;
		answer.delay = d;
		answer.width = w;
	endfunction

	function automatic void start_tx(input logic [7:0] d, input logic [5:0] size);
		tx_byte  = d;
		bit_pos  = '0;
		last_pos = size - 6'd1;
		tx_busy  = 1'b1;
	endfunction

	function automatic void next_image_byte();
		logic [71:0] img;
		int          total;
		int          idx;
		total = from_pad ? 9 : 8;
		img   = from_pad ? pad_of() : {8'h00, rom_now};
		idx   = (total - int'(bytes_left)) % total;
		start_tx(img[8*idx +: 8], 6'd8);
	endfunction

	function automatic void next_search_bit();
		search_bit = rom_now[search_pos[5:0]];
		// bit then its complement
		start_tx(search_bit ? 8'd1 : 8'd2, 6'd2);
	endfunction

	function automatic void run_command(input logic [7:0] c);
		link = LINK_DATA;
		case (c)
			owts_pkg::CMD_READ_ROM: begin
				from_pad   = 1'b0;
				bytes_left = 4'd8;
				next_image_byte();
			end
			owts_pkg::CMD_CONVERT: begin
				link = LINK_IDLE;
				if (!parasite)
					pull_low(owts_pkg::SLOT_DELAY, owts_pkg::BUSY_WIDTH);
			end
			owts_pkg::CMD_MATCH_ROM: begin
				last_pos = 6'd63;
				link     = LINK_MATCH;
			end
			owts_pkg::CMD_READ_POWER: ;
			owts_pkg::CMD_READ_PAD: begin
				from_pad   = 1'b1;
				bytes_left = 4'd9;
				next_image_byte();
			end
			owts_pkg::CMD_SKIP_ROM: link = LINK_COMMAND;
			owts_pkg::CMD_SEARCH_ROM: begin
				link       = LINK_SEARCH;
				search_pos = '0;
				next_search_bit();
			end
			default: link = LINK_IDLE;
		endcase
	endfunction

	function automatic void byte_done();
		case (link)
			LINK_COMMAND: begin
				answer.got_byte = 1'b1;
				answer.data     = rx_shift;
				run_command(rx_shift);
			end
			LINK_DATA: begin
				answer.got_byte = 1'b1;
				answer.data     = rx_shift;
			end
			LINK_MATCH: link = LINK_COMMAND;
			LINK_SEARCH: begin
				if (rx_shift[0] != search_bit) begin
					link = LINK_IDLE;
				end else begin
					search_pos = search_pos + 7'd1;
					if (search_pos >= 7'd64)
						link = LINK_IDLE;
					else
						next_search_bit();
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void take_bit(input logic b);
		if (link == LINK_MATCH) begin
			if (b != rom_now[bit_pos])
				link = LINK_IDLE;
		end else if (b) begin
			rx_shift[bit_pos[2:0]] = 1'b1;
		end
		if (bit_pos == last_pos) begin
			bit_pos  = '0;
			last_pos = 6'd7;
			byte_done();
			rx_shift = '0;
		end else begin
			bit_pos = bit_pos + 6'd1;
		end
	endfunction

	function automatic void give_bit();
		if (!tx_byte[bit_pos[2:0]])
			pull_low(owts_pkg::SLOT_DELAY, owts_pkg::ZERO_WIDTH);
		if (bit_pos == last_pos) begin
			bit_pos = '0;
			tx_busy = 1'b0;
			if (link == LINK_SEARCH) begin
				// the master's choice bit comes next
				last_pos = '0;
			end else if (bytes_left != 0) begin
				bytes_left = bytes_left - 4'd1;
				if (bytes_left != 0)
					next_image_byte();
			end
		end else begin
			bit_pos = bit_pos + 6'd1;
		end
	endfunction

	function automatic void predict_slot(input logic [11:0] t);
		answer = '0;
		if (t > owts_pkg::RESET_MIN_US) begin
			rx_shift   = '0;
			bit_pos    = '0;
			last_pos   = 6'd7;
			link       = LINK_COMMAND;
			tx_busy    = 1'b0;
			bytes_left = '0;
			pull_low(owts_pkg::PRESENCE_DELAY, owts_pkg::PRESENCE_WIDTH);
		end else if (link != LINK_IDLE) begin
			if (t > owts_pkg::ZERO_MIN_US) begin
				if (tx_busy)
					answer.err = 1'b1;
				else
					take_bit(1'b0);
			end else begin
				if (tx_busy)
					give_bit();
				else
					take_bit(1'b1);
			end
		end
		answer.state = link;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic compare_field(input string what, input int got, input int want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restore_defaults();
			expected_answers.delete();
			awaiting  <= 0;
			rom_image <= rom_now;
		end else begin
			if (cfg_we)
				apply_register(cfg_index, cfg_data);
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					report_mismatch("result beat with nothing expected", 1, 0);
				end else begin
					oldest = expected_answers.pop_front();
					compare_field("pulse_request", pulse_request, oldest.req);
					compare_field("pulse_delay_us", pulse_delay_us, oldest.delay);
					compare_field("pulse_width_us", pulse_width_us, oldest.width);
					compare_field("protocol_state", protocol_state, oldest.state);
					compare_field("slot_error", slot_error, oldest.err);
					compare_field("byte_valid", byte_valid, oldest.got_byte);
					compare_field("received_byte", received_byte, oldest.data);
				end
			end
			if (in_valid && !in_stall) begin
				predict_slot(low_time_us);
				expected_answers.insert(expected_answers.size(), answer);
			end
			awaiting  <= expected_answers.size();
			rom_image <= rom_now;
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives master pulses into the one-wire slave: a short directed run, then
// random bus transactions (ROM read, match, search, scratchpad, convert and
// broken or noisy sequences) under several register settings, with random
// idling on both channels and one long result hold-off
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ITEM_GOAL   = 950;
	localparam int PHASES      = 6;
	localparam int HOLD_CYCLES = 120;

	logic                             clk        = 1'b0;
	logic                             arst_n     = 1'b0;
	logic                             cfg_we     = 1'b0;
	logic [owts_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
	logic [owts_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;
	logic                             in_valid   = 1'b0;
	logic                             in_stall;
	logic [11:0]                      low_time_us = '0;
	logic                             out_valid;
	logic                             out_stall  = 1'b0;
	logic                             pulse_request;
	logic [4:0]                       pulse_delay_us;
	logic [9:0]                       pulse_width_us;
	logic [2:0]                       protocol_state;
	logic                             slot_error;
	logic                             byte_valid;
	logic [7:0]                       received_byte;

	int          fail_count;
	int          awaiting;
	logic [63:0] rom_image;

	int   items     = 0;
	logic steady    = 1'b0;
	logic hold_req  = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	one_wire_thermometer_slave #(
		.TIME_BITS(12)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.low_time_us   (low_time_us),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pulse_request (pulse_request),
		.pulse_delay_us(pulse_delay_us),
		.pulse_width_us(pulse_width_us),
		.protocol_state(protocol_state),
		.slot_error    (slot_error),
		.byte_valid    (byte_valid),
		.received_byte (received_byte)
	);

	owts_slot_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.low_time_us   (low_time_us),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pulse_request (pulse_request),
		.pulse_delay_us(pulse_delay_us),
		.pulse_width_us(pulse_width_us),
		.protocol_state(protocol_state),
		.slot_error    (slot_error),
		.byte_valid    (byte_valid),
		.received_byte (received_byte),
		.fail_count    (fail_count),
		.awaiting      (awaiting),
		.rom_image     (rom_image)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: random stalls, one long hold-off so the slave backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (steady) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 35);
		end
	end

	task automatic offer_pulse(input int t);
		while (!steady && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		low_time_us <= t[11:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items++;
	endtask

	task automatic bus_reset();
		offer_pulse($urandom_range(owts_pkg::RESET_MIN_US + 1, 4095));
	endtask

	task automatic send_bit(input logic b);
		if (b)
			offer_pulse($urandom_range(0, owts_pkg::ZERO_MIN_US));
		else
			offer_pulse($urandom_range(owts_pkg::ZERO_MIN_US + 1, owts_pkg::RESET_MIN_US));
	endtask

	task automatic send_byte(input logic [7:0] v);
		for (int i = 0; i < 8; i++)
			send_bit(v[i]);
	endtask

	// read slots, now and then a long pulse on top of a slave bit
	task automatic read_slots(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 6)
				offer_pulse($urandom_range(owts_pkg::ZERO_MIN_US + 1,
					owts_pkg::RESET_MIN_US));
			else
				offer_pulse($urandom_range(0, owts_pkg::ZERO_MIN_US));
		end
	endtask

	task automatic write_register(input logic [owts_pkg::CFG_INDEX_W-1:0] idx,
			input logic [owts_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
	endtask

	task automatic configure(input int ph);
		logic [11:0] temp12;
		logic [63:0] sn;
		if (ph == 0) begin
			temp12 = 12'(-880);
			write_register(owts_pkg::REG_TEMPERATURE, {36'd0, temp12});
			write_register(owts_pkg::REG_ALARM_HIGH, '0);
			write_register(owts_pkg::REG_ALARM_LOW, '0);
			write_register(owts_pkg::REG_CONFIG_BYTE, '0);
			write_register(owts_pkg::REG_SERIAL, '0);
			write_register(owts_pkg::REG_PARASITE, '0);
		end else if (ph == 1) begin
			temp12 = 12'd2000;
			write_register(owts_pkg::REG_TEMPERATURE, {36'd0, temp12});
			write_register(owts_pkg::REG_ALARM_HIGH, 48'd255);
			write_register(owts_pkg::REG_ALARM_LOW, 48'd255);
			write_register(owts_pkg::REG_CONFIG_BYTE, 48'd255);
			write_register(owts_pkg::REG_SERIAL, {48{1'b1}});
			write_register(owts_pkg::REG_PARASITE, 48'd1);
		end else begin
			temp12 = 12'($urandom_range(0, 2880) - 880);
			sn     = {$urandom(), $urandom()};
			if ($urandom_range(0, 9) < 6)
				write_register(owts_pkg::REG_TEMPERATURE, {36'd0, temp12});
			if ($urandom_range(0, 9) < 6)
				write_register(owts_pkg::REG_ALARM_HIGH, {40'd0, 8'($urandom())});
			if ($urandom_range(0, 9) < 6)
				write_register(owts_pkg::REG_ALARM_LOW, {40'd0, 8'($urandom())});
			if ($urandom_range(0, 9) < 6)
				write_register(owts_pkg::REG_CONFIG_BYTE, {40'd0, 8'($urandom())});
			if ($urandom_range(0, 9) < 7)
				write_register(owts_pkg::REG_SERIAL, sn[47:0]);
			if ($urandom_range(0, 9) < 6)
				write_register(owts_pkg::REG_PARASITE, {47'd0, 1'($urandom())});
		end
	endtask

	task automatic run_transaction();
		int          kind;
		int          flip;
		logic        wrong;
		logic [7:0]  cmd;
		kind = $urandom_range(0, 9);
		// a few sequences start from wherever the link was left
		if ($urandom_range(0, 99) < 90)
			bus_reset();
		case (kind)
			0, 1: begin
				send_byte(owts_pkg::CMD_SKIP_ROM);
				send_byte(owts_pkg::CMD_READ_PAD);
				read_slots($urandom_range(8, 80));
			end
			2: begin
				send_byte(owts_pkg::CMD_READ_ROM);
				read_slots($urandom_range(8, 72));
			end
			3, 4: begin
				send_byte(owts_pkg::CMD_MATCH_ROM);
				flip = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 63) : 64;
				for (int i = 0; i < 64; i++)
					send_bit(rom_image[i] ^ (i == flip));
				if ($urandom_range(0, 1) == 1) begin
					send_byte(owts_pkg::CMD_READ_PAD);
					read_slots($urandom_range(8, 76));
				end else begin
					send_byte(owts_pkg::CMD_CONVERT);
				end
			end
			5, 6: begin
				send_byte(owts_pkg::CMD_SEARCH_ROM);
				for (int i = 0; i < 64; i++) begin
					read_slots(2);
					wrong = ($urandom_range(0, 99) < 2);
					send_bit(rom_image[i] ^ wrong);
					if (wrong)
						break;
				end
			end
			7: begin
				send_byte(owts_pkg::CMD_SKIP_ROM);
				case ($urandom_range(0, 5))
					0: cmd = owts_pkg::CMD_CONVERT;
					1: cmd = owts_pkg::CMD_READ_POWER;
					2: cmd = owts_pkg::CMD_READ_ROM;
					3: cmd = owts_pkg::CMD_SEARCH_ROM;
					4: cmd = owts_pkg::CMD_MATCH_ROM;
					default: cmd = owts_pkg::CMD_SKIP_ROM;
				endcase
				send_byte(cmd);
				read_slots($urandom_range(0, 24));
			end
			8: begin
				send_byte(8'($urandom()));
				read_slots($urandom_range(0, 10));
			end
			default: begin
				repeat ($urandom_range(4, 24)) begin
					if ($urandom_range(0, 99) < 15)
						offer_pulse($urandom_range(0, 4095));
					else
						offer_pulse($urandom_range(0, 200));
				end
			end
		endcase
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle slave ignores everything short of a bus reset
		offer_pulse(0);
		offer_pulse(owts_pkg::ZERO_MIN_US);
		offer_pulse(owts_pkg::ZERO_MIN_US + 1);
		offer_pulse(owts_pkg::RESET_MIN_US);
		offer_pulse(4095);
		// skip ROM, bits at the slot-time boundaries, LSB first
		offer_pulse(owts_pkg::ZERO_MIN_US + 1);
		offer_pulse(owts_pkg::RESET_MIN_US);
		offer_pulse(0);
		offer_pulse(owts_pkg::ZERO_MIN_US);
		offer_pulse(owts_pkg::RESET_MIN_US);
		offer_pulse(owts_pkg::ZERO_MIN_US + 1);
		offer_pulse(owts_pkg::ZERO_MIN_US);
		offer_pulse(0);
		send_byte(owts_pkg::CMD_CONVERT);
		offer_pulse(owts_pkg::RESET_MIN_US + 1);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			configure(ph);
			steady <= (ph == 1);
			if (ph == 2)
				hold_req <= 1'b1;
			while (items < (ph + 1) * ITEM_GOAL / PHASES)
				run_transaction();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		for (int w = 0; w < 20000 && awaiting != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && awaiting == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
